// File: hw/rtl/gbba_pkg.sv
package gbba_pkg;

  // field widths
  localparam int BlockW   = 32;
  localparam int ModeW    = 2;
  localparam int StatusW  = 2;
  localparam int GroupsW  = 5;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;

  // request modes
  typedef enum logic [ModeW-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_FORMAT = 2'd2
  } mode_e;

  // response status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEGMENT_START = 4'd0;
  localparam logic [CfgIdxW-1:0] CFG_GROUPS_IN_USE = 4'd1;

endpackage

// File: hw/rtl/gbba_if.sv
// request channel
interface gbba_req_if;
  logic                         valid;
  logic                         ready;
  logic [gbba_pkg::ModeW-1:0]   mode;
  logic [gbba_pkg::BlockW-1:0]  block_number;

  modport source (output valid, mode, block_number, input ready);
  modport sink   (input valid, mode, block_number, output ready);
endinterface

// response channel
interface gbba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gbba_pkg::StatusW-1:0]  status;
  logic [gbba_pkg::BlockW-1:0]   granted_block;

  modport source (output valid, status, granted_block, input ready);
  modport sink   (input valid, status, granted_block, output ready);
endinterface

// configuration write channel
interface gbba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbba_pkg::CfgIdxW-1:0]   index;
  logic [gbba_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/gbba_ffz.sv
module gbba_ffz #(
  parameter int Width = 64
) (
  input  logic [Width-1:0]         bits_i,
  output logic                     found_o,
  output logic [$clog2(Width)-1:0] idx_o
);

  // lowest clear bit wins: scan from the top so lower bits overwrite
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = Width - 1; i >= 0; i--) begin
      if (!bits_i[i]) begin
        found_o = 1'b1;
        idx_o   = ($clog2(Width))'(i);
      end
    end
  end

endmodule

// File: hw/rtl/grouped_bitmap_block_allocator.sv
// Block allocator over a segment of groups, each one bitmap header block followed by
// BLOCKS_PER_GROUP data blocks; groups that are not full sit on a linked free list.
// An allocate word returns the lowest free block of the head group, a free word
// clears the bit of its block and relinks a group that was full, and a format word
// clears all bitmaps and relinks every group in order. One request word is taken
// per clock while the receiver keeps up; each word passes the stage 1 register, then
// the result register: as the word is taken, its block number is mapped to group and
// offset with a reciprocal multiply; stage 2 reads and updates the group state
// (find-first-zero and list head), so back-to-back requests always see the state left
// by the previous one. A stalled receiver backs up the stage register and then the
// input. Bitmaps come out of reset and format all free. Configuration is to be written
// only while no request is in flight; the user must see to it, the block does not.
module grouped_bitmap_block_allocator #(
  parameter int MAX_GROUPS       = 16,
  parameter int BLOCKS_PER_GROUP = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbba_req_if.sink   req_i,
  gbba_rsp_if.source rsp_o,
  gbba_cfg_if.sink   cfg_i
);

  localparam int Span = BLOCKS_PER_GROUP + 1;
  localparam int DivL = $clog2(Span);
  localparam int DivS = gbba_pkg::BlockW + DivL;
  localparam logic [32:0] DivM =
      33'(((64'd1 << DivS) + 64'(Span) - 64'd1) / 64'(Span));
  localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int LW = $clog2(MAX_GROUPS + 1);
  localparam int KW = $clog2(BLOCKS_PER_GROUP);
  localparam int PW = $clog2(Span);
  localparam int BW = gbba_pkg::BlockW;

  // configuration registers
  logic [BW-1:0]                segment_start_q;
  logic [gbba_pkg::GroupsW-1:0] groups_in_use_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      segment_start_q <= '0;
      groups_in_use_q <= gbba_pkg::GroupsW'(16);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == gbba_pkg::CFG_SEGMENT_START) begin
        segment_start_q <= cfg_i.data;
      end else if (cfg_i.index == gbba_pkg::CFG_GROUPS_IN_USE) begin
        groups_in_use_q <= cfg_i.data[gbba_pkg::GroupsW-1:0];
      end
    end
  end

  // pipeline handshake
  logic s1_valid_q;
  logic res_valid_q;
  logic out_free;
  logic s2_adv;
  logic s1_take;

  assign out_free    = !res_valid_q || rsp_o.ready;
  assign s2_adv      = s1_valid_q && out_free;
  assign req_i.ready = !s1_valid_q || s2_adv;
  assign s1_take     = req_i.valid && req_i.ready;

  // stage 1: offset into segment and group number by reciprocal multiply
  logic [BW:0]        off_ext;
  logic [2*BW:0]      prod;
  logic [BW-1:0]      quo;

  assign off_ext = {1'b0, req_i.block_number} - {1'b0, segment_start_q};
  assign prod    = (2*BW+1)'(off_ext[BW-1:0]) * (2*BW+1)'(DivM);
  assign quo     = BW'(prod >> DivS);

  gbba_pkg::mode_e s1_mode_q;
  logic            s1_below_q;
  logic            s1_gbig_q;
  logic [GW-1:0]   s1_gidx_q;
  logic [PW-1:0]   s1_offlo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      s1_mode_q  <= gbba_pkg::mode_e'(req_i.mode);
      s1_below_q <= off_ext[BW];
      s1_gbig_q  <= quo >= BW'(MAX_GROUPS);
      s1_gidx_q  <= quo[GW-1:0];
      s1_offlo_q <= off_ext[PW-1:0];
    end
  end

  // group state
  logic [BLOCKS_PER_GROUP-1:0] used_q  [MAX_GROUPS];
  logic [LW-1:0]               next_q  [MAX_GROUPS];
  logic [MAX_GROUPS-1:0]       gvalid_q;
  logic [GW-1:0]               head_q;
  logic                        nonempty_q;

  // effective group count
  logic [LW-1:0] eff_groups;
  always_comb begin
    if (groups_in_use_q == '0) begin
      eff_groups = LW'(1);
    end else if (32'(groups_in_use_q) > 32'(MAX_GROUPS)) begin
      eff_groups = LW'(MAX_GROUPS);
    end else begin
      eff_groups = LW'(groups_in_use_q);
    end
  end

  // single read port of the group state
  logic [GW-1:0]               rd_idx;
  logic [BLOCKS_PER_GROUP-1:0] rd_used;
  logic [LW-1:0]               rd_next;

  assign rd_idx  = (s1_mode_q == gbba_pkg::MODE_FREE) ? s1_gidx_q : head_q;
  assign rd_used = gvalid_q[rd_idx] ? used_q[rd_idx] : '0;
  assign rd_next = gvalid_q[rd_idx] ? next_q[rd_idx] : LW'(rd_idx) + LW'(1);

  logic          ffz_found;
  logic [KW-1:0] ffz_idx;

  gbba_ffz #(
    .Width (BLOCKS_PER_GROUP)
  ) u_ffz (
    .bits_i  (rd_used),
    .found_o (ffz_found),
    .idx_o   (ffz_idx)
  );

  // stage 2: allocate and free decisions
  logic                        alloc_ok;
  logic [BLOCKS_PER_GROUP-1:0] alloc_bits;
  logic [BW-1:0]               alloc_block;
  logic [PW-1:0]               pos;
  logic [PW-1:0]               pos_m1;
  logic                        free_ok;
  logic                        was_full;

  assign alloc_ok    = nonempty_q && (LW'(head_q) < eff_groups) && ffz_found;
  assign alloc_bits  = rd_used | (BLOCKS_PER_GROUP'(1) << ffz_idx);
  assign alloc_block = segment_start_q + BW'(32'(head_q) * 32'(Span))
                       + BW'(ffz_idx) + BW'(1);

  assign pos      = s1_offlo_q - PW'(32'(s1_gidx_q) * 32'(Span));
  assign pos_m1   = pos - PW'(1);
  assign free_ok  = !s1_below_q && !s1_gbig_q && (LW'(s1_gidx_q) < eff_groups)
                    && (pos != '0);
  assign was_full = &rd_used;

  logic                        wr_en;
  logic [BLOCKS_PER_GROUP-1:0] wr_used;
  logic [LW-1:0]               wr_next;
  logic                        fmt;
  logic [GW-1:0]               head_d;
  logic                        nonempty_d;
  gbba_pkg::status_e           res_status_d;
  logic [BW-1:0]               res_granted_d;

  always_comb begin
    wr_en         = 1'b0;
    wr_used       = rd_used;
    wr_next       = rd_next;
    fmt           = 1'b0;
    head_d        = head_q;
    nonempty_d    = nonempty_q;
    res_status_d  = gbba_pkg::ST_OK;
    res_granted_d = '0;
    unique case (s1_mode_q)
      gbba_pkg::MODE_ALLOC: begin
        if (alloc_ok) begin
          wr_en         = 1'b1;
          wr_used       = alloc_bits;
          res_granted_d = alloc_block;
          if (&alloc_bits) begin
            if (rd_next < eff_groups) begin
              head_d = GW'(rd_next);
            end else begin
              nonempty_d = 1'b0;
            end
          end
        end else begin
          res_status_d = gbba_pkg::ST_NO_FREE;
        end
      end
      gbba_pkg::MODE_FREE: begin
        if (free_ok) begin
          wr_en   = 1'b1;
          wr_used = rd_used & ~(BLOCKS_PER_GROUP'(1) << pos_m1);
          if (was_full) begin
            wr_next    = nonempty_q ? LW'(head_q) : LW'(MAX_GROUPS);
            head_d     = s1_gidx_q;
            nonempty_d = 1'b1;
          end
        end else begin
          res_status_d = gbba_pkg::ST_BAD_ADDR;
        end
      end
      gbba_pkg::MODE_FORMAT: begin
        fmt        = 1'b1;
        head_d     = '0;
        nonempty_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gvalid_q   <= '0;
      head_q     <= '0;
      nonempty_q <= 1'b1;
    end else if (s2_adv) begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      if (fmt) begin
        gvalid_q <= '0;
      end else if (wr_en) begin
        gvalid_q[rd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && wr_en) begin
      used_q[rd_idx] <= wr_used;
      next_q[rd_idx] <= wr_next;
    end
  end

  // result register
  gbba_pkg::status_e res_status_q;
  logic [BW-1:0]     res_granted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      res_status_q  <= res_status_d;
      res_granted_q <= res_granted_d;
    end
  end

  assign rsp_o.valid         = res_valid_q;
  assign rsp_o.status        = res_status_q;
  assign rsp_o.granted_block = res_granted_q;

`ifndef NO_ASSERTIONS
  // a group that was full and gets a block back is always on the list afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_adv && s1_mode_q == gbba_pkg::MODE_FREE && free_ok && was_full)
      |=> (nonempty_q && $past(s1_gidx_q) == head_q))
    else $error("freed full group not pushed onto list");

  // failed requests never carry a block number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q != gbba_pkg::ST_OK) |-> (res_granted_q == '0))
    else $error("error response with nonzero block");

  // a stage 1 word that cannot move on stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_adv) |=> s1_valid_q)
    else $error("stage 1 word dropped");

  // format leaves a nonempty list headed by group zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_adv && s1_mode_q == gbba_pkg::MODE_FORMAT)
      |=> (nonempty_q && head_q == '0 && gvalid_q == '0))
    else $error("format did not rebuild the list");
`endif

endmodule

// File: tb/grouped_bitmap_block_allocator_test.sv
module grouped_bitmap_block_allocator_test;

  localparam int MaxGroups      = 16;
  localparam int BlocksPerGroup = 64;
  localparam int GroupSpan      = BlocksPerGroup + 1;
  localparam int WatchdogLimit  = 4000;

  // mode code the block does not define, must be a no-op
  localparam logic [gbba_pkg::ModeW-1:0] ModeSpare = 2'd3;

  typedef struct packed {
    gbba_pkg::status_e           status;
    logic [gbba_pkg::BlockW-1:0] granted;
  } alloc_rsp_t;

  logic clk;
  logic rst_n;

  gbba_req_if req ();
  gbba_rsp_if rsp ();
  gbba_cfg_if cfg ();

  grouped_bitmap_block_allocator #(
    .MAX_GROUPS      (MaxGroups),
    .BLOCKS_PER_GROUP(BlocksPerGroup)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp),
    .cfg_i (cfg)
  );

  // allocator mirror: bitmaps, free list and registers
  logic [BlocksPerGroup-1:0]    grp_used [MaxGroups];
  logic [4:0]                   grp_link [MaxGroups];
  logic [3:0]                   list_head_q;
  bit                           list_live;
  logic [gbba_pkg::BlockW-1:0]  seg_base;
  logic [gbba_pkg::GroupsW-1:0] grp_count;

  alloc_rsp_t                  awaited_rsp [$];
  logic [gbba_pkg::BlockW-1:0] live_blocks [$];

  int src_idle_pct  = 0;
  int rsp_stall_pct = 0;
  int rsp_hold_left = 0;
  int stall_cycles  = 0;
  int err_cnt       = 0;
  int req_cnt       = 0;
  int rsp_cnt       = 0;
  int cfg_cnt       = 0;
  int alloc_ok_cnt  = 0;
  int no_free_cnt   = 0;
  int bad_addr_cnt  = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int unsigned group_limit();
    if (grp_count == 0) return 1;
    if (grp_count > MaxGroups) return MaxGroups;
    return grp_count;
  endfunction

  function automatic void clear_groups();
    for (int i = 0; i < MaxGroups; i++) begin
      grp_used[i] = '0;
      grp_link[i] = 5'(i + 1);
    end
    list_head_q = '0;
    list_live   = 1'b1;
  endfunction

  // next response of the allocator, updates the mirror
  function automatic alloc_rsp_t predict_allocation(logic [gbba_pkg::ModeW-1:0] m,
                                                    logic [gbba_pkg::BlockW-1:0] b);
    alloc_rsp_t                  r;
    int unsigned                 limit;
    int unsigned                 g;
    int unsigned                 pos;
    int                          k;
    logic [gbba_pkg::BlockW-1:0] off;
    logic [4:0]                  nx;
    bit                          was_full;
    r.status  = gbba_pkg::ST_OK;
    r.granted = '0;
    limit     = group_limit();
    case (m)
      gbba_pkg::MODE_ALLOC: begin
        if (!list_live || list_head_q >= limit) begin
          r.status = gbba_pkg::ST_NO_FREE;
        end else begin
          k = 0;
          while (k < BlocksPerGroup && grp_used[list_head_q][k]) k++;
          if (k >= BlocksPerGroup) begin
            r.status = gbba_pkg::ST_NO_FREE;
          end else begin
            grp_used[list_head_q][k] = 1'b1;
            r.granted = seg_base + 32'(list_head_q) * 32'(GroupSpan) + 32'd1 + 32'(k);
            // group just filled: pop it
            if (&grp_used[list_head_q]) begin
              nx = grp_link[list_head_q];
              if (nx < limit) list_head_q = nx[3:0];
              else list_live = 1'b0;
            end
          end
        end
      end
      gbba_pkg::MODE_FREE: begin
        if (b < seg_base) begin
          r.status = gbba_pkg::ST_BAD_ADDR;
        end else begin
          off = b - seg_base;
          g   = off / GroupSpan;
          pos = off % GroupSpan;
          if (g >= limit || pos == 0) begin
            r.status = gbba_pkg::ST_BAD_ADDR;
          end else begin
            was_full = &grp_used[g];
            grp_used[g][pos-1] = 1'b0;
            // full group goes back on the list head
            if (was_full) begin
              grp_link[g] = list_live ? 5'(list_head_q) : 5'(MaxGroups);
              list_head_q = 4'(g);
              list_live   = 1'b1;
            end
          end
        end
      end
      gbba_pkg::MODE_FORMAT: clear_groups();
      default: ;
    endcase
    return r;
  endfunction

  // free addresses that miss the data blocks or hit free ones
  function automatic logic [gbba_pkg::BlockW-1:0] odd_block();
    case ($urandom_range(4))
      0: return $urandom;
      1: return seg_base - 32'($urandom_range(1, 8));
      2: return seg_base + 32'($urandom_range(17)) * 32'(GroupSpan);
      3: return seg_base + 32'(group_limit()) * 32'(GroupSpan) + 32'($urandom_range(1, 64));
      default: return seg_base + 32'($urandom_range(group_limit() - 1)) * 32'(GroupSpan)
                      + 32'($urandom_range(1, 64));
    endcase
  endfunction

  // send one request word, entered and left at a falling edge
  task automatic send_req(input logic [gbba_pkg::ModeW-1:0] m,
                          input logic [gbba_pkg::BlockW-1:0] b);
    alloc_rsp_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid        = 1'b1;
    req.mode         = m;
    req.block_number = b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = predict_allocation(m, b);
    awaited_rsp.push_back(r);
    req_cnt++;
    if (m == gbba_pkg::MODE_FORMAT) live_blocks.delete();
    if (m == gbba_pkg::MODE_ALLOC && r.status == gbba_pkg::ST_OK) begin
      live_blocks.push_back(r.granted);
    end
    case (r.status)
      gbba_pkg::ST_NO_FREE:  no_free_cnt++;
      gbba_pkg::ST_BAD_ADDR: bad_addr_cnt++;
      default:               if (m == gbba_pkg::MODE_ALLOC) alloc_ok_cnt++;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid = 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
  endtask

  // register write, only with nothing in flight
  task automatic write_cfg(input logic [gbba_pkg::CfgIdxW-1:0] idx,
                           input logic [gbba_pkg::CfgDataW-1:0] data);
    wait_drained();
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      gbba_pkg::CFG_SEGMENT_START: seg_base  = data;
      gbba_pkg::CFG_GROUPS_IN_USE: grp_count = data[gbba_pkg::GroupsW-1:0];
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // mix of allocates, frees of live blocks, odd frees, formats and spare words
  task automatic run_random(input int n);
    int                          pick;
    int                          idx;
    logic [gbba_pkg::BlockW-1:0] b;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60 || (pick < 88 && live_blocks.size() == 0)) begin
        send_req(gbba_pkg::MODE_ALLOC, $urandom);
      end else if (pick < 88) begin
        idx = $urandom_range(live_blocks.size() - 1);
        b   = live_blocks[idx];
        live_blocks.delete(idx);
        send_req(gbba_pkg::MODE_FREE, b);
      end else if (pick < 95) begin
        send_req(gbba_pkg::MODE_FREE, odd_block());
      end else if (pick < 97) begin
        send_req(gbba_pkg::MODE_FORMAT, $urandom);
      end else begin
        send_req(ModeSpare, $urandom);
      end
    end
  endtask

  // field extremes, header and outside addresses, spare mode, group count clamps
  task automatic test_directed();
    src_idle_pct  = 0;
    rsp_stall_pct = 0;
    send_req(gbba_pkg::MODE_ALLOC, 32'hFFFF_FFFF);
    send_req(gbba_pkg::MODE_ALLOC, 32'h0000_0000);
    send_req(gbba_pkg::MODE_FREE, 32'd1);
    send_req(gbba_pkg::MODE_FREE, 32'd1);
    send_req(gbba_pkg::MODE_FREE, 32'd0);
    send_req(gbba_pkg::MODE_FREE, 32'(GroupSpan));
    send_req(gbba_pkg::MODE_FREE, 32'(MaxGroups * GroupSpan));
    send_req(gbba_pkg::MODE_FREE, 32'(MaxGroups * GroupSpan - 1));
    send_req(gbba_pkg::MODE_FREE, 32'hFFFF_FFFF);
    send_req(ModeSpare, 32'hFFFF_FFFF);
    send_req(gbba_pkg::MODE_FORMAT, 32'hFFFF_FFFF);
    send_req(gbba_pkg::MODE_ALLOC, 32'h5555_AAAA);
    write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'd1000);
    send_req(gbba_pkg::MODE_FREE, 32'd999);
    send_req(gbba_pkg::MODE_FREE, 32'd1000);
    send_req(gbba_pkg::MODE_ALLOC, 32'hAAAA_5555);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd0);
    send_req(gbba_pkg::MODE_FREE, 32'(1000 + GroupSpan + 1));
    send_req(gbba_pkg::MODE_ALLOC, 32'd0);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd31);
    send_req(gbba_pkg::MODE_FREE, 32'(1000 + 15 * GroupSpan + 1));
    send_req(gbba_pkg::MODE_FREE, 32'(1000 + 16 * GroupSpan + 1));
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd17);
    send_req(gbba_pkg::MODE_ALLOC, 32'd0);
  endtask

  // granted block numbers that wrap past the top of the 32-bit range
  task automatic test_wrapped_blocks();
    write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'hFFFF_FFFC);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd1);
    send_req(gbba_pkg::MODE_FORMAT, 32'd0);
    repeat (5) send_req(gbba_pkg::MODE_ALLOC, $urandom);
    send_req(gbba_pkg::MODE_FREE, 32'd0);
    send_req(gbba_pkg::MODE_FREE, 32'hFFFF_FFFF);
    write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'hFFFF_FFFF);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
  endtask

  // fill a group, stale head after shrinking the count, empty list, push back
  task automatic test_full_groups();
    src_idle_pct  = 12;
    rsp_stall_pct = 12;
    write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'd5000);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd2);
    send_req(gbba_pkg::MODE_FORMAT, 32'd0);
    repeat (BlocksPerGroup) send_req(gbba_pkg::MODE_ALLOC, $urandom);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd1);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
    send_req(gbba_pkg::MODE_FREE, 32'd5011);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd2);
    send_req(gbba_pkg::MODE_ALLOC, $urandom);
    send_req(gbba_pkg::MODE_FREE, 32'd5064);
    send_req(gbba_pkg::MODE_FREE, 32'd5001);
    repeat (3) send_req(gbba_pkg::MODE_ALLOC, $urandom);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd16);
    src_idle_pct  = 0;
    rsp_stall_pct = 0;
    @(posedge clk);
    rsp_hold_left = 200;
    @(negedge clk);
    run_random(60);
    wait_drained();
  endtask

  // random traffic under each idle mix, config changed without format
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd1);
          write_cfg(gbba_pkg::CFG_SEGMENT_START, $urandom);
          src_idle_pct  = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd3);
          write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'd0);
          src_idle_pct  = 75;
          rsp_stall_pct = 0;
        end
        2: begin
          write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'($urandom_range(31)));
          write_cfg(gbba_pkg::CFG_SEGMENT_START, $urandom);
          src_idle_pct  = 0;
          rsp_stall_pct = 75;
        end
        default: begin
          write_cfg(gbba_pkg::CFG_GROUPS_IN_USE, 32'd2);
          write_cfg(gbba_pkg::CFG_SEGMENT_START, 32'hFFFF_FF00);
          src_idle_pct  = 12;
          rsp_stall_pct = 12;
        end
      endcase
      run_random(135);
    end
  endtask

  // receiver ready, long hold counted here
  always @(negedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp.ready = 1'b0;
      rsp_hold_left--;
    end else begin
      rsp.ready = ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // compare each response word with the oldest expectation
  always @(posedge clk) begin : check_rsp
    alloc_rsp_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (awaited_rsp.size() == 0) begin
        $display("%0t: unexpected response status=%0d granted=%h", $time, rsp.status,
                 rsp.granted_block);
        err_cnt++;
      end else begin
        want = awaited_rsp.pop_front();
        rsp_cnt++;
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d got %0d", $time, want.status,
                   rsp.status);
          err_cnt++;
        end
        if (rsp.granted_block !== want.granted) begin
          $display("%0t: granted block mismatch, expected %h got %h", $time, want.granted,
                   rsp.granted_block);
          err_cnt++;
        end
      end
    end
  end

  // end the run when no word moves for too long
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    req.valid        = 1'b0;
    req.mode         = '0;
    req.block_number = '0;
    cfg.valid        = 1'b0;
    cfg.index        = '0;
    cfg.data         = '0;
    seg_base         = '0;
    grp_count        = 5'd16;
    clear_groups();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_wrapped_blocks();
    test_full_groups();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d requests, %0d responses checked, %0d register writes",
             req_cnt, rsp_cnt, cfg_cnt);
    $display("grants %0d, no free block %0d, bad address %0d, under four idle mixes",
             alloc_ok_cnt, no_free_cnt, bad_addr_cnt);
    if (err_cnt == 0 && awaited_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
